/* hdl/cross_difference_grid_vote_defines.svh */
// Assertion macros shared by the checker of the grid vote block.
`ifndef CROSS_DIFFERENCE_GRID_VOTE_DEFINES_SVH
`define CROSS_DIFFERENCE_GRID_VOTE_DEFINES_SVH

`define CDGV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CDGV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`define CDGV_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cdgv_pkg.sv */
package cdgv_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W      = 8;
    localparam int DIFF_W     = 9;
    localparam int SUM_W      = 10;
    localparam int SIZE_W     = 13;
    localparam int WIN_W      = 12;
    localparam int COUNT_W    = 21;
    localparam int GRID       = 8;
    localparam int GRID_W     = $clog2(GRID);
    localparam int NUM_BINS   = 2 * GRID;
    localparam int BIN_IDX_W  = $clog2(NUM_BINS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [SIZE_W-1:0]  SIZE_MIN     = SIZE_W'(4);
    localparam logic [SIZE_W-1:0]  SIZE_RESET   = SIZE_W'(4096);
    localparam logic [WIN_W-1:0]   WIN_HI_RESET = {WIN_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_WIN_X0       = 3'd2,
        CFG_WIN_Y0       = 3'd3,
        CFG_WIN_X1       = 3'd4,
        CFG_WIN_Y1       = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pixel_item;

    typedef struct packed {
        logic               axis;
        logic [GRID_W-1:0]  phase;
        logic [COUNT_W-1:0] vote_count;
        logic               last;
    } t_vote_item;

    // One line buffer entry: the pixel of the row above and the two
    // difference rows of the cell to its left.
    typedef struct packed {
        logic [DIFF_W-1:0] diff_prev;
        logic [DIFF_W-1:0] diff_curr;
        logic [PIX_W-1:0]  pixel;
    } t_line_word;

    typedef struct packed {
        logic              valid;
        logic              clear;
        logic              col_hit;
        logic [GRID_W-1:0] col_bin;
        logic              row_hit;
        logic [GRID_W-1:0] row_bin;
        logic              frame_end;
    } t_vote_upd;

endpackage

/* hdl/cdgv_stream_if.sv */
interface cdgv_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hdl/cdgv_line_mem.sv */
module cdgv_line_mem #(
    parameter int DEPTH = cdgv_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output cdgv_pkg::t_line_word o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  cdgv_pkg::t_line_word i_wr_data
);

    cdgv_pkg::t_line_word r_mem [DEPTH];
    cdgv_pkg::t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/cdgv_vote_bins.sv */
module cdgv_vote_bins (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdgv_pkg::t_vote_upd i_upd,
    output logic                o_busy,
    cdgv_stream_if.source       o_vote
);

    logic [cdgv_pkg::COUNT_W-1:0]   r_col_cnt [cdgv_pkg::GRID];
    logic [cdgv_pkg::COUNT_W-1:0]   r_row_cnt [cdgv_pkg::GRID];
    logic [cdgv_pkg::COUNT_W-1:0]   r_bank    [cdgv_pkg::NUM_BINS];
    logic [cdgv_pkg::BIN_IDX_W-1:0] r_idx;
    logic                           r_full;

    logic [cdgv_pkg::COUNT_W-1:0]   n_col_cnt [cdgv_pkg::GRID];
    logic [cdgv_pkg::COUNT_W-1:0]   n_row_cnt [cdgv_pkg::GRID];
    cdgv_pkg::t_vote_item           vote_item;
    logic                           out_xfer;
    logic                           load;

    always_comb begin
        logic [cdgv_pkg::COUNT_W-1:0] base_c;
        logic [cdgv_pkg::COUNT_W-1:0] base_r;
        for (int i = 0; i < cdgv_pkg::GRID; i++) begin
            base_c = i_upd.clear ? '0 : r_col_cnt[i];
            base_r = i_upd.clear ? '0 : r_row_cnt[i];
            n_col_cnt[i] = base_c;
            n_row_cnt[i] = base_r;
            if (i_upd.col_hit && i_upd.col_bin == cdgv_pkg::GRID_W'(i)
                && base_c != cdgv_pkg::COUNT_MAX) begin
                n_col_cnt[i] = base_c + cdgv_pkg::COUNT_W'(1);
            end
            if (i_upd.row_hit && i_upd.row_bin == cdgv_pkg::GRID_W'(i)
                && base_r != cdgv_pkg::COUNT_MAX) begin
                n_row_cnt[i] = base_r + cdgv_pkg::COUNT_W'(1);
            end
        end
    end

    assign load     = i_upd.valid && i_upd.frame_end;
    assign out_xfer = o_vote.valid && o_vote.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cdgv_pkg::GRID; i++) begin
                r_col_cnt[i] <= '0;
                r_row_cnt[i] <= '0;
            end
            r_idx  <= '0;
            r_full <= 1'b0;
        end else begin
            if (i_upd.valid) begin
                for (int i = 0; i < cdgv_pkg::GRID; i++) begin
                    r_col_cnt[i] <= i_upd.frame_end ? '0 : n_col_cnt[i];
                    r_row_cnt[i] <= i_upd.frame_end ? '0 : n_row_cnt[i];
                end
            end
            if (load) begin
                r_full <= 1'b1;
                r_idx  <= '0;
            end else if (out_xfer) begin
                r_idx <= r_idx + cdgv_pkg::BIN_IDX_W'(1);
                if (r_idx == cdgv_pkg::BIN_IDX_W'(cdgv_pkg::NUM_BINS - 1)) begin
                    r_full <= 1'b0;
                end
            end
        end
    end

    // The bank holds a finished frame while the next one is counted.
    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < cdgv_pkg::GRID; i++) begin
                r_bank[i]                 <= n_col_cnt[i];
                r_bank[cdgv_pkg::GRID + i] <= n_row_cnt[i];
            end
        end
    end

    always_comb begin
        vote_item.axis       = r_idx[cdgv_pkg::BIN_IDX_W-1];
        vote_item.phase      = r_idx[cdgv_pkg::GRID_W-1:0];
        vote_item.vote_count = r_bank[r_idx];
        vote_item.last       = (r_idx == cdgv_pkg::BIN_IDX_W'(cdgv_pkg::NUM_BINS - 1));
    end

    assign o_vote.valid   = r_full;
    assign o_vote.payload = vote_item;
    assign o_busy         = r_full;

endmodule

/* hdl/cross_difference_grid_vote.sv */
// Grid vote front end for blocky compression artefacts.
// Pixels enter on i_pix, eight-bit grey values in raster order, one transfer
// per pixel; frame_start marks the first pixel of a frame and clears the
// position and all counts. Registers are written on the plain configuration
// port; the user must write them only while the block is idle, as the block
// itself does not enforce it. The block takes one pixel per clock cycle
// unless the input is held back as told below. A pixel is read from the
// single line buffer memory in the cycle of its transfer and finished, with
// write-back, in the next; adjacent accesses to the same entry are forwarded.
// After the last pixel of a frame the sixteen bin counts appear on o_vote,
// the first once the bank is loaded, then one per cycle while the receiver
// is ready: column bins 0 to 7, row bins 0 to 7, with last on the sixteenth.
// The counts sit in a holding bank, so the next frame streams in meanwhile.
// If the receiver stalls, the results wait in the bank; the input is held
// back only when a frame's last pixel is due and the bank is still full.
// Reset returns the registers to their defaults, sets the position to the
// origin and clears the counts; the line buffer is not cleared, and every
// row needs a complete row above it before it is voted on.
module cross_difference_grid_vote #(
    parameter int MAX_WIDTH  = cdgv_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cdgv_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cdgv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cdgv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cdgv_stream_if.sink                     i_pix,
    cdgv_stream_if.source                   o_vote
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int XPW = (XW > cdgv_pkg::WIN_W) ? XW : cdgv_pkg::WIN_W;
    localparam int YPW = (YW > cdgv_pkg::WIN_W) ? YW : cdgv_pkg::WIN_W;
    localparam int DW  = cdgv_pkg::DIFF_W;
    localparam int SW  = cdgv_pkg::SUM_W;

    logic [cdgv_pkg::SIZE_W-1:0] r_cfg_width;
    logic [cdgv_pkg::SIZE_W-1:0] r_cfg_height;
    logic [cdgv_pkg::WIN_W-1:0]  r_win_x0;
    logic [cdgv_pkg::WIN_W-1:0]  r_win_y0;
    logic [cdgv_pkg::WIN_W-1:0]  r_win_x1;
    logic [cdgv_pkg::WIN_W-1:0]  r_win_y1;

    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;

    logic                        r_s1_valid;
    logic [XW-1:0]               r_s1_col;
    logic [YW-1:0]               r_s1_row;
    logic [cdgv_pkg::PIX_W-1:0]  r_s1_pixel;
    logic                        r_s1_clear;
    logic                        r_s1_end;
    logic                        r_s1_byp;
    cdgv_pkg::t_line_word        r_s1_byp_word;

    logic [cdgv_pkg::PIX_W-1:0]  r_nw_ul;
    logic [cdgv_pkg::PIX_W-1:0]  r_nw_left;
    logic [DW-1:0]               r_nw_d2;
    logic [DW-1:0]               r_nw_d1;

    logic [XW-1:0]               w_last;
    logic [YW-1:0]               h_last;
    logic                        pix_xfer;
    logic [XW-1:0]               c0;
    logic [YW-1:0]               r0;
    logic                        col_end;
    logic                        row_end;
    logic                        pos_last;
    logic                        bank_busy;
    cdgv_pkg::t_pixel_item       pix_item;

    cdgv_pkg::t_line_word        rd_word;
    cdgv_pkg::t_line_word        line;
    cdgv_pkg::t_line_word        wr_word;
    logic [SW-1:0]               sum_a;
    logic [SW-1:0]               sum_b;
    logic [DW-1:0]               d;
    logic                        active;
    logic [XW-1:0]               hx;
    logic [YW-1:0]               hy;
    logic [XW-1:0]               vx;
    logic [YW-1:0]               vy;
    logic                        h_in_win;
    logic                        v_in_win;
    cdgv_pkg::t_vote_upd         upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= cdgv_pkg::SIZE_RESET;
            r_cfg_height <= cdgv_pkg::SIZE_RESET;
            r_win_x0     <= '0;
            r_win_y0     <= '0;
            r_win_x1     <= cdgv_pkg::WIN_HI_RESET;
            r_win_y1     <= cdgv_pkg::WIN_HI_RESET;
        end else if (i_cfg_we) begin
            case (cdgv_pkg::t_cfg_index'(i_cfg_index))
                cdgv_pkg::CFG_IMAGE_WIDTH: begin
                    r_cfg_width <= i_cfg_data;
                end
                cdgv_pkg::CFG_IMAGE_HEIGHT: begin
                    r_cfg_height <= i_cfg_data;
                end
                cdgv_pkg::CFG_WIN_X0: begin
                    r_win_x0 <= i_cfg_data[cdgv_pkg::WIN_W-1:0];
                end
                cdgv_pkg::CFG_WIN_Y0: begin
                    r_win_y0 <= i_cfg_data[cdgv_pkg::WIN_W-1:0];
                end
                cdgv_pkg::CFG_WIN_X1: begin
                    r_win_x1 <= i_cfg_data[cdgv_pkg::WIN_W-1:0];
                end
                cdgv_pkg::CFG_WIN_Y1: begin
                    r_win_y1 <= i_cfg_data[cdgv_pkg::WIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Last column and last row after clamping the sizes.
    always_comb begin
        if (r_cfg_width < cdgv_pkg::SIZE_MIN) begin
            w_last = XW'(3);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_last = XW'(MAX_WIDTH - 1);
        end else begin
            w_last = XW'(r_cfg_width - cdgv_pkg::SIZE_W'(1));
        end
        if (r_cfg_height < cdgv_pkg::SIZE_MIN) begin
            h_last = YW'(3);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            h_last = YW'(MAX_HEIGHT - 1);
        end else begin
            h_last = YW'(r_cfg_height - cdgv_pkg::SIZE_W'(1));
        end
    end

    assign pix_item = i_pix.payload;
    assign pix_xfer = i_pix.valid && i_pix.ready;
    assign c0       = pix_item.frame_start ? '0 : r_col;
    assign r0       = pix_item.frame_start ? '0 : r_row;
    assign col_end  = (c0 >= w_last);
    assign row_end  = (r0 >= h_last);
    assign pos_last = (r_col >= w_last) && (r_row >= h_last);

    assign i_pix.ready = !(bank_busy && pos_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= pix_xfer;
            if (pix_xfer) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r0 + YW'(1);
                end else begin
                    r_col <= c0 + XW'(1);
                    r_row <= r0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_xfer) begin
            r_s1_col      <= c0;
            r_s1_row      <= r0;
            r_s1_pixel    <= pix_item.pixel;
            r_s1_clear    <= pix_item.frame_start;
            r_s1_end      <= col_end && row_end;
            r_s1_byp      <= r_s1_valid && (r_s1_col == c0);
            r_s1_byp_word <= wr_word;
        end
    end

    cdgv_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (pix_xfer),
        .i_rd_addr (c0),
        .o_rd_data (rd_word),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_word)
    );

    assign line = r_s1_byp ? r_s1_byp_word : rd_word;

    // Cross difference of the cell whose lower right pixel is arriving.
    assign sum_a = SW'(r_nw_ul) + SW'(r_s1_pixel);
    assign sum_b = SW'(line.pixel) + SW'(r_nw_left);
    assign d     = (sum_a >= sum_b) ? DW'(sum_a - sum_b) : DW'(sum_b - sum_a);

    assign active = (r_s1_col != '0) && (r_s1_row != '0);
    assign hx     = r_s1_col - XW'(2);
    assign hy     = r_s1_row - YW'(1);
    assign vx     = r_s1_col - XW'(1);
    assign vy     = r_s1_row - YW'(2);

    assign h_in_win = (XPW'(hx) >= XPW'(r_win_x0)) && (XPW'(hx) <= XPW'(r_win_x1))
                   && (YPW'(hy) >= YPW'(r_win_y0)) && (YPW'(hy) <= YPW'(r_win_y1));
    assign v_in_win = (XPW'(vx) >= XPW'(r_win_x0)) && (XPW'(vx) <= XPW'(r_win_x1))
                   && (YPW'(vy) >= YPW'(r_win_y0)) && (YPW'(vy) <= YPW'(r_win_y1));

    always_comb begin
        wr_word.pixel     = r_s1_pixel;
        wr_word.diff_prev = active ? line.diff_curr : line.diff_prev;
        wr_word.diff_curr = active ? d : line.diff_curr;
    end

    always_comb begin
        upd.valid     = r_s1_valid;
        upd.clear     = r_s1_clear;
        upd.frame_end = r_s1_end;
        upd.col_bin   = hx[cdgv_pkg::GRID_W-1:0];
        upd.row_bin   = vy[cdgv_pkg::GRID_W-1:0];
        upd.col_hit   = r_s1_valid && active && (r_s1_col >= XW'(3))
                     && (r_s1_col <= w_last) && (r_s1_row <= h_last) && h_in_win
                     && (r_nw_d1 > r_nw_d2) && (r_nw_d1 > d);
        upd.row_hit   = r_s1_valid && active && (r_s1_row >= YW'(3))
                     && (r_s1_row <= h_last) && (r_s1_col <= w_last) && v_in_win
                     && (line.diff_curr > line.diff_prev) && (line.diff_curr > d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nw_ul   <= '0;
            r_nw_left <= '0;
            r_nw_d2   <= '0;
            r_nw_d1   <= '0;
        end else if (r_s1_valid) begin
            r_nw_ul   <= line.pixel;
            r_nw_left <= r_s1_pixel;
            if (active) begin
                r_nw_d2 <= r_nw_d1;
                r_nw_d1 <= d;
            end
        end
    end

    cdgv_vote_bins u_vote_bins (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_busy  (bank_busy),
        .o_vote  (o_vote)
    );

endmodule

/* hdl/cdgv_checker.sv */
`include "cross_difference_grid_vote_defines.svh"

module cdgv_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_axis,
    input logic [cdgv_pkg::GRID_W-1:0]       i_phase,
    input logic [cdgv_pkg::COUNT_W-1:0]      i_vote_count,
    input logic                              i_last
);

    `CDGV_ASSERT_RESET(a_no_result_after_reset, !i_out_valid, "result offered after reset")

    `CDGV_ASSERT_SAME(a_stall_only_when_full, i_in_valid && !i_in_ready, i_out_valid, "input held back with no results pending")

    `CDGV_ASSERT_NEXT(a_bins_in_order, i_out_valid && i_out_ready && !i_last, i_out_valid && ((i_axis == $past(i_axis) && i_phase == $past(i_phase) + 3'd1) || (i_axis && !$past(i_axis) && i_phase == 3'd0)), "bin sequence broken")

    `CDGV_ASSERT_NEXT(a_result_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_axis) && $stable(i_phase) && $stable(i_vote_count) && $stable(i_last), "stalled result changed")

endmodule

bind cross_difference_grid_vote cdgv_checker u_cdgv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_vote.valid),
    .i_out_ready  (o_vote.ready),
    .i_axis       (o_vote.payload.axis),
    .i_phase      (o_vote.payload.phase),
    .i_vote_count (o_vote.payload.vote_count),
    .i_last       (o_vote.payload.last)
);

/* verif/cross_difference_grid_vote_tb.sv */
module cross_difference_grid_vote_tb;
    import cdgv_pkg::*;

    localparam int unsigned MAX_W          = MAX_WIDTH_DEF;
    localparam int unsigned MAX_H          = MAX_HEIGHT_DEF;
    localparam int unsigned RANDOM_ITEMS   = 380;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef struct {
        bit          hold;
        t_pixel_item pix;
    } t_pix_feed;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cdgv_stream_if #(.t_payload(t_pixel_item)) pix_if ();
    cdgv_stream_if #(.t_payload(t_vote_item))  vote_if ();

    cross_difference_grid_vote DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_if.sink),
        .o_vote      (vote_if.source)
    );

    // Own copy of the block's registers and state.
    bit [SIZE_W-1:0]  grid_width;
    bit [SIZE_W-1:0]  grid_height;
    bit [WIN_W-1:0]   vote_x0, vote_y0, vote_x1, vote_y1;
    bit [PIX_W-1:0]   line_pix   [MAX_W];
    bit [DIFF_W-1:0]  diff_above [MAX_W];
    bit [DIFF_W-1:0]  diff_here  [MAX_W];
    bit [COUNT_W-1:0] col_votes  [GRID];
    bit [COUNT_W-1:0] row_votes  [GRID];
    int unsigned      col_pos, row_pos;
    bit [PIX_W-1:0]   pix_upleft, pix_left;
    bit [DIFF_W-1:0]  diff_left2, diff_left1;

    t_vote_item  vote_expect_q [$];
    t_pix_feed   pix_feed_q [$];
    t_vote_item  vote_want;
    int unsigned fail_count;
    int unsigned random_items;
    int unsigned idle_cycles;
    bit          pix_taken;

    bit          sender_bursty;
    int unsigned burst_left, gap_left;
    int unsigned sink_mode;
    bit [15:0]   sink_pattern;
    int unsigned sink_step, sink_hold;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input bit [SIZE_W-1:0] v, input int unsigned hi);
        if (v < 4) return 4;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit in_vote_window(input int unsigned x, input int unsigned y);
        return x >= vote_x0 && x <= vote_x1 && y >= vote_y0 && y <= vote_y1;
    endfunction

    function automatic void clear_votes();
        for (int k = 0; k < GRID; k++) begin
            col_votes[k] = '0;
            row_votes[k] = '0;
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    task automatic absorb_pixel(input t_pixel_item px);
        int unsigned     w, h, c, r, hx, hy, vx, vy;
        int              s;
        bit [DIFF_W-1:0] d, cur, above;
        bit [PIX_W-1:0]  up;
        t_vote_item      res;
        w = clamp_dim(grid_width, MAX_W);
        h = clamp_dim(grid_height, MAX_H);
        if (px.frame_start) clear_votes();
        c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
        r = row_pos;
        up = line_pix[c];
        if (c >= 1 && r >= 1) begin
            s = int'(pix_upleft) + int'(px.pixel) - int'(up) - int'(pix_left);
            d = DIFF_W'((s < 0) ? -s : s);
            hx = c - 2;
            hy = r - 1;
            vx = c - 1;
            vy = r - 2;
            cur = diff_here[vx];
            above = diff_above[vx];
            if (c >= 3 && hx + 3 <= w && hy + 2 <= h && in_vote_window(hx, hy)
                    && diff_left1 > diff_left2 && diff_left1 > d) begin
                if (col_votes[hx % GRID] != COUNT_MAX) col_votes[hx % GRID]++;
            end
            if (r >= 3 && vy + 3 <= h && vx + 2 <= w && in_vote_window(vx, vy)
                    && cur > above && cur > d) begin
                if (row_votes[vy % GRID] != COUNT_MAX) row_votes[vy % GRID]++;
            end
            diff_above[vx] = cur;
            diff_here[vx] = d;
            diff_left2 = diff_left1;
            diff_left1 = d;
        end
        pix_upleft = up;
        pix_left = px.pixel;
        line_pix[c] = px.pixel;
        if (c + 1 >= w) begin
            if (r + 1 >= h) begin
                for (int k = 0; k < NUM_BINS; k++) begin
                    res.axis = (k >= GRID);
                    res.phase = GRID_W'(k % GRID);
                    res.vote_count = res.axis ? row_votes[k % GRID] : col_votes[k % GRID];
                    res.last = (k == NUM_BINS - 1);
                    vote_expect_q.push_back(res);
                end
                clear_votes();
            end else begin
                col_pos = 0;
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge i_clk) begin
        pix_taken <= i_rst_n && pix_if.valid && pix_if.ready;
        if (i_rst_n) begin
            if (pix_if.valid && pix_if.ready) absorb_pixel(pix_if.payload);
            if (vote_if.valid && vote_if.ready) begin
                if (vote_expect_q.size() == 0) begin
                    $error("Unexpected vote transfer: axis %0d phase %0d count %0d",
                           vote_if.payload.axis, vote_if.payload.phase,
                           vote_if.payload.vote_count);
                    fail_count++;
                end else begin
                    vote_want = vote_expect_q.pop_front();
                    if (vote_if.payload.axis !== vote_want.axis) begin
                        $error("axis: expected %0d, got %0d", vote_want.axis,
                               vote_if.payload.axis);
                        fail_count++;
                    end
                    if (vote_if.payload.phase !== vote_want.phase) begin
                        $error("phase: expected %0d, got %0d", vote_want.phase,
                               vote_if.payload.phase);
                        fail_count++;
                    end
                    if (vote_if.payload.vote_count !== vote_want.vote_count) begin
                        $error("vote_count: expected %0d, got %0d", vote_want.vote_count,
                               vote_if.payload.vote_count);
                        fail_count++;
                    end
                    if (vote_if.payload.last !== vote_want.last) begin
                        $error("last: expected %0d, got %0d", vote_want.last,
                               vote_if.payload.last);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (vote_if.valid && vote_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Pixel sender: back to back or in bursts with gaps, and a hold entry that waits for all results.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || pix_taken) begin
            if (gap_left != 0) begin
                pix_if.valid <= 1'b0;
                gap_left--;
            end else if (pix_feed_q.size() != 0 && pix_feed_q[0].hold) begin
                pix_if.valid <= 1'b0;
                if (vote_expect_q.size() == 0) void'(pix_feed_q.pop_front());
            end else if (pix_feed_q.size() != 0) begin
                pix_if.payload <= pix_feed_q[0].pix;
                void'(pix_feed_q.pop_front());
                pix_if.valid <= 1'b1;
                if (sender_bursty) begin
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            vote_if.ready <= 1'b0;
        end else if (sink_hold != 0) begin
            vote_if.ready <= 1'b0;
            sink_hold--;
        end else begin
            case (sink_mode)
                0: begin
                    vote_if.ready <= 1'b1;
                end
                1: begin
                    vote_if.ready <= sink_pattern[sink_step % 16];
                    sink_step++;
                end
                default: begin
                    if ($urandom_range(0, 19) == 0) begin
                        sink_hold = $urandom_range(5, 30);
                        vote_if.ready <= 1'b0;
                    end else begin
                        vote_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    function automatic bit [PIX_W-1:0] draw_pixel(input int unsigned style);
        case (style)
            0: return PIX_W'($urandom_range(0, 255));
            1: return PIX_W'($urandom_range(0, 3));
            2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return PIX_W'($urandom_range(120, 136));
        endcase
    endfunction

    task automatic queue_pixels(input int unsigned count, input bit restart,
                                input int unsigned style);
        t_pix_feed e;
        e.hold = 1'b0;
        for (int unsigned i = 0; i < count; i++) begin
            e.pix.pixel = draw_pixel(style);
            e.pix.frame_start = restart && (i == 0);
            pix_feed_q.push_back(e);
        end
    endtask

    task automatic queue_hold();
        t_pix_feed e;
        e.hold = 1'b1;
        e.pix = '0;
        pix_feed_q.push_back(e);
    endtask

    task automatic write_reg(input t_cfg_index idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        case (idx)
            CFG_IMAGE_WIDTH:  grid_width = SIZE_W'(val);
            CFG_IMAGE_HEIGHT: grid_height = SIZE_W'(val);
            CFG_WIN_X0:       vote_x0 = WIN_W'(val);
            CFG_WIN_Y0:       vote_y0 = WIN_W'(val);
            CFG_WIN_X1:       vote_x1 = WIN_W'(val);
            CFG_WIN_Y1:       vote_y1 = WIN_W'(val);
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned x0, input int unsigned y0,
                                input int unsigned x1, input int unsigned y1);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_WIN_X0, x0);
        write_reg(CFG_WIN_Y0, y0);
        write_reg(CFG_WIN_X1, x1);
        write_reg(CFG_WIN_Y1, y1);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic pick_handshake_modes();
        sender_bursty = $urandom_range(0, 2) != 0;
        burst_left = $urandom_range(1, 24);
        sink_mode = $urandom_range(0, 2);
        sink_pattern = 16'($urandom()) | 16'h0001;
    endtask

    // Waits until every pixel is sent and every count has arrived, then lets the pipe settle.
    task automatic wait_drained();
        do @(posedge i_clk); while (pix_feed_q.size() != 0 || pix_if.valid);
        do @(negedge i_clk); while (vote_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int unsigned w_raw, h_raw, w_eff, h_eff, x0, y0, x1, y1;
        int unsigned frames, style, prefix, batch;
        bit          restart;
        bit [7:0]    opening_frame [16] = '{8'd0, 8'd255, 8'd0, 8'd255,
                                           8'd255, 8'd0, 8'd0, 8'd0,
                                           8'd0, 8'd255, 8'd128, 8'd255,
                                           8'd17, 8'd0, 8'd255, 8'd1};
        t_pix_feed   e;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.payload = '0;
        vote_if.ready = 1'b0;
        fail_count = 0;
        random_items = 0;
        gap_left = 0;
        sink_hold = 0;
        sink_step = 0;
        grid_width = SIZE_RESET;
        grid_height = SIZE_RESET;
        vote_x0 = '0;
        vote_y0 = '0;
        vote_x1 = WIN_HI_RESET;
        vote_y1 = WIN_HI_RESET;
        pix_upleft = '0;
        pix_left = '0;
        diff_left2 = '0;
        diff_left1 = '0;
        clear_votes();
        sender_bursty = 1'b0;
        burst_left = 1;
        sink_mode = 0;
        sink_pattern = 16'hFFFF;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sizes below the minimum clamp to 4 by 4; a full frame, a short frame, then a restart.
        set_geometry(3, 0, 0, 0, 4095, 4095);
        e.hold = 1'b0;
        for (int i = 0; i < 16; i++) begin
            e.pix.pixel = opening_frame[i];
            e.pix.frame_start = (i == 0);
            pix_feed_q.push_back(e);
        end
        queue_hold();
        queue_pixels(4, 1'b1, 2);
        queue_pixels(16, 1'b1, 0);
        wait_drained();

        while (random_items < RANDOM_ITEMS) begin
            pick_handshake_modes();
            w_raw = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 16);
            h_raw = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 10);
            w_eff = clamp_dim(SIZE_W'(w_raw), MAX_W);
            h_eff = clamp_dim(SIZE_W'(h_raw), MAX_H);
            case ($urandom_range(0, 4))
                0: begin
                    x0 = 0;
                    y0 = 0;
                    x1 = 4095;
                    y1 = 4095;
                end
                1: begin
                    x0 = $urandom_range(0, w_eff - 1);
                    x1 = $urandom_range(x0, w_eff - 1);
                    y0 = $urandom_range(0, h_eff - 1);
                    y1 = $urandom_range(y0, h_eff - 1);
                end
                2: begin
                    x0 = $urandom_range(0, w_eff - 1);
                    x1 = $urandom_range(w_eff, 4095);
                    y0 = $urandom_range(0, h_eff - 1);
                    y1 = $urandom_range(h_eff, 4095);
                end
                3: begin
                    if ($urandom_range(0, 1)) begin
                        x0 = $urandom_range(1, 4095);
                        x1 = $urandom_range(0, x0 - 1);
                        y0 = 0;
                        y1 = 4095;
                    end else begin
                        x0 = 0;
                        x1 = 4095;
                        y0 = $urandom_range(1, 4095);
                        y1 = $urandom_range(0, y0 - 1);
                    end
                end
                default: begin
                    x0 = $urandom_range(0, 4095);
                    x1 = $urandom_range(0, 4095);
                    y0 = $urandom_range(0, 4095);
                    y1 = $urandom_range(0, 4095);
                end
            endcase
            set_geometry(w_raw, h_raw, x0, y0, x1, y1);
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++) begin
                style = $urandom_range(0, 3);
                restart = $urandom_range(0, 1);
                if ($urandom_range(0, 7) == 0) begin
                    prefix = $urandom_range(1, w_eff * h_eff - 1);
                    queue_pixels(prefix, restart, style);
                    random_items += prefix;
                    restart = 1'b1;
                end
                batch = w_eff * h_eff;
                queue_pixels(batch, restart, style);
                random_items += batch;
                if ($urandom_range(0, 4) == 0) queue_hold();
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
